// ----- hw/rtl/mip_chain_layout_generator_defines.svh -----
// Assertion macros for the mip chain layout generator.
`ifndef MIP_CHAIN_LAYOUT_GENERATOR_DEFINES_SVH
`define MIP_CHAIN_LAYOUT_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCL_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mcl: same-cycle check failed");
`define MCL_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mcl: next-cycle check failed");
`else
`define MCL_ASSERT_IMP(lbl, clk, rst, pre, post)
`define MCL_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- hw/rtl/mcl_pkg.sv -----
package mcl_pkg;

   localparam int MAX_EXTENT   = 16384;
   localparam int MAX_LEVELS   = 15;
   localparam int OFFSET_ALIGN = 16;

   localparam int EXT_W     = 15;
   localparam int DEPTH_W   = 12;
   localparam int LAYER_W   = 12;
   localparam int LEVEL_W   = 4;
   localparam int BLK_W     = 4;
   localparam int BYTES_W   = 6;
   localparam int OFS_W     = 46;
   localparam int PROD_W    = 60;
   localparam int MUL_A_W   = 54;
   localparam int DIV_CNT_W = 4;
   localparam int STEP_W    = 4;

   localparam logic [OFS_W-1:0] SAT46      = '1;
   localparam logic [OFS_W-1:0] ALIGN_MASK = OFS_W'(OFFSET_ALIGN - 1);

   // sequencer step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DIVX    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_WAITX   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIVY    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_WAITY   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_BY  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_LAY = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MUL_DEP = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MUL_BYT = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SIZE    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;

   localparam logic [1:0] BR_NEXT  = 2'd0;
   localparam logic [1:0] BR_START = 2'd1;
   localparam logic [1:0] BR_DIV   = 2'd2;
   localparam logic [1:0] BR_LEVEL = 2'd3;

   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_LOAD   = 3'd1;
   localparam logic [2:0] MUL_BY     = 3'd2;
   localparam logic [2:0] MUL_LAYERS = 3'd3;
   localparam logic [2:0] MUL_DEPTH  = 3'd4;
   localparam logic [2:0] MUL_BYTES  = 3'd5;

   localparam logic DIV_X = 1'b0;
   localparam logic DIV_Y = 1'b1;

   typedef struct packed {
      logic [EXT_W-1:0]   base_width;
      logic [EXT_W-1:0]   base_height;
      logic [DEPTH_W-1:0] base_depth;
      logic [LAYER_W-1:0] layer_count;
      logic [LEVEL_W-1:0] level_request;
      logic [BLK_W-1:0]   block_width;
      logic [BLK_W-1:0]   block_height;
      logic [BYTES_W-1:0] block_bytes;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_index;
      logic [OFS_W-1:0]   level_offset;
      logic [OFS_W-1:0]   level_bytes;
      logic [EXT_W-1:0]   level_width;
      logic [EXT_W-1:0]   level_height;
      logic [DEPTH_W-1:0] level_depth;
      logic [EXT_W-1:0]   blocks_per_row;
      logic [EXT_W-1:0]   block_rows;
      logic [EXT_W-1:0]   padded_row_texels;
      logic [EXT_W-1:0]   padded_height_texels;
      logic [OFS_W-1:0]   total_bytes;
      logic               last_level;
   } rsp_type;

   typedef struct packed {
      logic              div_go;
      logic              div_sel;
      logic              div_wait;
      logic              align_en;
      logic [2:0]        mul_op;
      logic              size_en;
      logic              emit;
      logic [1:0]        branch;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   localparam ctrl_type CTRL_NOP = '{
      div_go: 1'b0, div_sel: DIV_X, div_wait: 1'b0, align_en: 1'b0,
      mul_op: MUL_NONE, size_en: 1'b0, emit: 1'b0,
      branch: BR_NEXT, target: STEP_IDLE};

   // microcode ROM: one control word per step
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] pc);
      ctrl_type c;
      c = CTRL_NOP;
      case (pc)
         STEP_IDLE: begin
            c.branch = BR_START;
            c.target = STEP_DIVX;
         end
         STEP_DIVX: begin
            c.div_go   = 1'b1;
            c.div_sel  = DIV_X;
            c.align_en = 1'b1;
         end
         STEP_WAITX: begin
            c.div_sel  = DIV_X;
            c.div_wait = 1'b1;
            c.branch   = BR_DIV;
         end
         STEP_DIVY: begin
            c.div_go  = 1'b1;
            c.div_sel = DIV_Y;
            c.mul_op  = MUL_LOAD;
         end
         STEP_WAITY: begin
            c.div_sel  = DIV_Y;
            c.div_wait = 1'b1;
            c.branch   = BR_DIV;
         end
         STEP_MUL_BY:  c.mul_op = MUL_BY;
         STEP_MUL_LAY: c.mul_op = MUL_LAYERS;
         STEP_MUL_DEP: c.mul_op = MUL_DEPTH;
         STEP_MUL_BYT: c.mul_op = MUL_BYTES;
         STEP_SIZE:    c.size_en = 1'b1;
         STEP_EMIT: begin
            c.emit   = 1'b1;
            c.branch = BR_LEVEL;
            c.target = STEP_DIVX;
         end
         default: c.branch = BR_LEVEL;
      endcase
      return c;
   endfunction

   function automatic logic [EXT_W-1:0] fix_ext(input logic [EXT_W-1:0] v);
      logic [EXT_W-1:0] r;
      if (v == '0) r = EXT_W'(1);
      else if (v > EXT_W'(MAX_EXTENT)) r = EXT_W'(MAX_EXTENT);
      else r = v;
      return r;
   endfunction

   function automatic logic [DEPTH_W-1:0] fix_depth(input logic [DEPTH_W-1:0] v);
      logic [DEPTH_W-1:0] r;
      if (v == '0) r = DEPTH_W'(1);
      else r = v;
      return r;
   endfunction

   function automatic logic [EXT_W-1:0] halve_ext(input logic [EXT_W-1:0] v);
      logic [EXT_W-1:0] r;
      r = v >> 1;
      if (r == '0) r = EXT_W'(1);
      return r;
   endfunction

   function automatic logic [DEPTH_W-1:0] halve_depth(input logic [DEPTH_W-1:0] v);
      logic [DEPTH_W-1:0] r;
      r = v >> 1;
      if (r == '0) r = DEPTH_W'(1);
      return r;
   endfunction

   // floor(log2(largest extent)) + 1
   function automatic logic [LEVEL_W-1:0] chain_levels(input logic [EXT_W-1:0] w,
                                                      input logic [EXT_W-1:0] h,
                                                      input logic [DEPTH_W-1:0] d);
      logic [EXT_W-1:0]   m;
      logic [LEVEL_W-1:0] n;
      m = w;
      if (h > m) m = h;
      if (EXT_W'(d) > m) m = EXT_W'(d);
      n = LEVEL_W'(1);
      for (int i = 1; i < EXT_W; i++) begin
         if (m[i]) n = LEVEL_W'(i + 1);
      end
      return n;
   endfunction

endpackage

// ----- hw/rtl/mcl_cdiv.sv -----
module mcl_cdiv (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [mcl_pkg::EXT_W-1:0]   num,
   input  logic [mcl_pkg::BLK_W-1:0]   dsr,
   output logic                        done,
   output logic [mcl_pkg::EXT_W-1:0]   quo
);
   import mcl_pkg::*;

   // ceiling divide, restoring, one quotient bit per cycle
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLK_W-1:0]     rem_ff, rem_in;
   logic [BLK_W-1:0]     dsr_ff, dsr_in;
   logic [EXT_W-1:0]     num_ff, num_in;
   logic [EXT_W-1:0]     quo_ff, quo_in;
   logic [BLK_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, num_ff[EXT_W-1]};
      fits      = trial >= {1'b0, dsr_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      if (go) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = '0;
         dsr_in    = dsr;
         num_in    = num + EXT_W'(dsr) - EXT_W'(1);
      end else if (active_ff) begin
         rem_in = fits ? BLK_W'(trial - {1'b0, dsr_ff}) : trial[BLK_W-1:0];
         quo_in = {quo_ff[EXT_W-2:0], fits};
         num_in = {num_ff[EXT_W-2:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(EXT_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- hw/rtl/mip_chain_layout_generator.sv -----
// Mip chain layout: one request word in (start while busy is low), one result word per mip
// level out on rsp_word, marked by rsp_strobe for exactly one cycle; the receiver cannot stall,
// so it must take every strobed word. For each level the bit-serial ceiling divider runs once
// for the block columns and once for the block rows, followed by the shared multiplier steps
// of the size product; busy stays high from the accept until the last level word appears.
// Byte sizes, offsets and totals saturate at 2^46-1; offsets are aligned up to 16 bytes.
`include "mip_chain_layout_generator_defines.svh"

module mip_chain_layout_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mcl_pkg::req_type req_word,
   output logic             rsp_strobe,
   output mcl_pkg::rsp_type rsp_word
);
   import mcl_pkg::*;

   ctrl_type ctrl;

   logic [STEP_W-1:0]  pc_ff, pc_in;
   logic [EXT_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [DEPTH_W-1:0] d_ff, d_in;
   logic [LAYER_W-1:0] layers_ff, layers_in;
   logic [BYTES_W-1:0] bbytes_ff, bbytes_in;
   logic [BLK_W-1:0]   bw_ff, bw_in, bh_ff, bh_in;
   logic [LEVEL_W-1:0] total_ff, total_in, lvl_ff, lvl_in;
   logic [OFS_W-1:0]   offset_ff, offset_in, size_ff, size_in;
   logic [EXT_W-1:0]   bx_ff, bx_in, by_ff, by_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   rsp_type            rsp_word_ff, rsp_word_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic               accept;
   logic [LEVEL_W-1:0] req_levels;
   logic [EXT_W-1:0]   fix_w, fix_h;
   logic [DEPTH_W-1:0] fix_d;
   logic               more;
   logic               last;
   logic [EXT_W-1:0]   div_num;
   logic [BLK_W-1:0]   div_dsr;
   logic               div_done;
   logic [EXT_W-1:0]   div_quo;
   logic [EXT_W-1:0]   mul_b;
   logic [MUL_A_W+EXT_W-1:0] mul_full;
   logic [OFS_W:0]     al_sum, al_val, end_sum;
   logic [OFS_W-1:0]   end_val;
   logic [EXT_W+BLK_W-1:0] pad_row, pad_col;

   assign ctrl   = ucode(pc_ff);
   assign busy   = pc_ff != STEP_IDLE;
   assign accept = start && !busy;

   assign div_num = (ctrl.div_sel == DIV_Y) ? h_ff : w_ff;
   assign div_dsr = (ctrl.div_sel == DIV_Y) ? bh_ff : bw_ff;

   mcl_cdiv u_cdiv (
      .clock (clock),
      .reset (reset),
      .go    (ctrl.div_go),
      .num   (div_num),
      .dsr   (div_dsr),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      fix_w = fix_ext(req_word.base_width);
      fix_h = fix_ext(req_word.base_height);
      fix_d = fix_depth(req_word.base_depth);
      if (req_word.level_request == '0) req_levels = chain_levels(fix_w, fix_h, fix_d);
      else req_levels = req_word.level_request;
      if (req_levels > LEVEL_W'(MAX_LEVELS)) req_levels = LEVEL_W'(MAX_LEVELS);

      more = ({1'b0, lvl_ff} + 5'd1) < {1'b0, total_ff};
      last = !more;

      case (ctrl.mul_op)
         MUL_BY:     mul_b = by_ff;
         MUL_LAYERS: mul_b = EXT_W'(layers_ff);
         MUL_DEPTH:  mul_b = EXT_W'(d_ff);
         MUL_BYTES:  mul_b = EXT_W'(bbytes_ff);
         default:    mul_b = '0;
      endcase
      mul_full = prod_ff[MUL_A_W-1:0] * mul_b;

      al_sum  = {1'b0, offset_ff} + {1'b0, ALIGN_MASK};
      al_val  = al_sum & ~{1'b0, ALIGN_MASK};
      end_sum = {1'b0, offset_ff} + {1'b0, size_ff};
      end_val = end_sum[OFS_W] ? SAT46 : end_sum[OFS_W-1:0];
      pad_row = (EXT_W+BLK_W)'(bx_ff) * (EXT_W+BLK_W)'(bw_ff);
      pad_col = (EXT_W+BLK_W)'(by_ff) * (EXT_W+BLK_W)'(bh_ff);

      case (ctrl.branch)
         BR_NEXT:  pc_in = pc_ff + STEP_W'(1);
         BR_START: pc_in = start ? ctrl.target : pc_ff;
         BR_DIV:   pc_in = div_done ? pc_ff + STEP_W'(1) : pc_ff;
         BR_LEVEL: pc_in = more ? ctrl.target : STEP_IDLE;
         default:  pc_in = STEP_IDLE;
      endcase

      w_in      = w_ff;
      h_in      = h_ff;
      d_in      = d_ff;
      layers_in = layers_ff;
      bbytes_in = bbytes_ff;
      bw_in     = bw_ff;
      bh_in     = bh_ff;
      total_in  = total_ff;
      lvl_in    = lvl_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      prod_in   = prod_ff;

      if (accept) begin
         w_in      = fix_w;
         h_in      = fix_h;
         d_in      = fix_d;
         layers_in = req_word.layer_count;
         bbytes_in = req_word.block_bytes;
         bw_in     = (req_word.block_width == '0) ? BLK_W'(1) : req_word.block_width;
         bh_in     = (req_word.block_height == '0) ? BLK_W'(1) : req_word.block_height;
         total_in  = req_levels;
         lvl_in    = '0;
         offset_in = '0;
      end

      if (ctrl.align_en) offset_in = al_val[OFS_W] ? SAT46 : al_val[OFS_W-1:0];

      if (ctrl.div_wait && div_done) begin
         if (ctrl.div_sel == DIV_Y) by_in = div_quo;
         else bx_in = div_quo;
      end

      if (ctrl.mul_op == MUL_LOAD) prod_in = PROD_W'(bx_ff);
      else if (ctrl.mul_op != MUL_NONE) prod_in = mul_full[PROD_W-1:0];

      if (ctrl.size_en) size_in = (prod_ff > PROD_W'(SAT46)) ? SAT46 : prod_ff[OFS_W-1:0];

      rsp_strobe_in = ctrl.emit;
      rsp_word_in   = rsp_word_ff;
      if (ctrl.emit) begin
         rsp_word_in.level_index          = lvl_ff;
         rsp_word_in.level_offset         = offset_ff;
         rsp_word_in.level_bytes          = size_ff;
         rsp_word_in.level_width          = w_ff;
         rsp_word_in.level_height         = h_ff;
         rsp_word_in.level_depth          = d_ff;
         rsp_word_in.blocks_per_row       = bx_ff;
         rsp_word_in.block_rows           = by_ff;
         rsp_word_in.padded_row_texels    = pad_row[EXT_W-1:0];
         rsp_word_in.padded_height_texels = pad_col[EXT_W-1:0];
         rsp_word_in.total_bytes          = end_val;
         rsp_word_in.last_level           = last;
         offset_in = end_val;
         w_in      = halve_ext(w_ff);
         h_in      = halve_ext(h_ff);
         d_in      = halve_depth(d_ff);
         lvl_in    = lvl_ff + LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      w_ff        <= w_in;
      h_ff        <= h_in;
      d_ff        <= d_in;
      layers_ff   <= layers_in;
      bbytes_ff   <= bbytes_in;
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      total_ff    <= total_in;
      lvl_ff      <= lvl_in;
      offset_ff   <= offset_in;
      size_ff     <= size_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `MCL_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `MCL_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `MCL_ASSERT_IMP(a_last_idle, clock, reset, rsp_strobe && rsp_word.last_level, !busy)
   `MCL_ASSERT_IMP(a_more_busy, clock, reset, rsp_strobe && !rsp_word.last_level, busy)

endmodule

// ----- test/mip_chain_layout_generator_tb.sv -----
`timescale 1ns / 100ps

module mip_chain_layout_generator_tb;
   import mcl_pkg::*;

   typedef struct {
      req_type word;
      bit      pinned;
      rsp_type level0;
   } row_type;

   localparam int RANDOM_WORDS = 160;
   localparam int SETTLE_CYCLES = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   rsp_type pending_levels [$];
   int      error_count = 0;
   int      requests_sent = 0;
   int      full_chains = 0;
   int      levels_checked = 0;
   int      saturated_levels = 0;
   int      burst_left = 0;

   mip_chain_layout_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #2 clock = ~clock;

   function automatic int fit_extent(input int v);
      return (v == 0) ? 1 : (v > MAX_EXTENT) ? MAX_EXTENT : v;
   endfunction

   function automatic int half_floor(input int v);
      return (v > 1) ? v / 2 : 1;
   endfunction

   function automatic longint unsigned cap46(input longint unsigned v);
      return (v > SAT46) ? longint'(SAT46) : v;
   endfunction

   // expected level words for one layout request
   function automatic void plan_mip_chain(input req_type w);
      int              wd, ht, dp, bw, bh, levels, m;
      longint unsigned bx, by, layers, bytes, size, ofs, fin;
      rsp_type         r;
      wd = fit_extent(w.base_width);
      ht = fit_extent(w.base_height);
      dp = fit_extent(w.base_depth);
      bw = (w.block_width == 0) ? 1 : w.block_width;
      bh = (w.block_height == 0) ? 1 : w.block_height;
      layers = w.layer_count;
      bytes = w.block_bytes;
      levels = w.level_request;
      if (levels == 0) begin
         m = (wd > ht) ? wd : ht;
         if (dp > m) m = dp;
         levels = 1;
         while (m > 1) begin
            m = m >> 1;
            levels++;
         end
      end
      if (levels > MAX_LEVELS) levels = MAX_LEVELS;
      ofs = 0;
      for (int lv = 0; lv < levels; lv++) begin
         bx = (wd + bw - 1) / bw;
         by = (ht + bh - 1) / bh;
         ofs = cap46((ofs + OFFSET_ALIGN - 1) / OFFSET_ALIGN * OFFSET_ALIGN);
         size = cap46(bx * by * layers * longint'(dp) * bytes);
         fin = cap46(ofs + size);
         if (size == SAT46) saturated_levels++;
         r.level_index = LEVEL_W'(lv);
         r.level_offset = OFS_W'(ofs);
         r.level_bytes = OFS_W'(size);
         r.level_width = EXT_W'(wd);
         r.level_height = EXT_W'(ht);
         r.level_depth = DEPTH_W'(dp);
         r.blocks_per_row = EXT_W'(bx);
         r.block_rows = EXT_W'(by);
         r.padded_row_texels = EXT_W'(bx * bw);
         r.padded_height_texels = EXT_W'(by * bh);
         r.total_bytes = OFS_W'(fin);
         r.last_level = (lv == levels - 1);
         pending_levels.push_back(r);
         ofs = fin;
         wd = half_floor(wd);
         ht = half_floor(ht);
         dp = half_floor(dp);
      end
   endfunction

   function automatic req_type mk_req(input int w, h, d, layers, lv, bw, bh, bb);
      req_type r;
      r.base_width = EXT_W'(w);
      r.base_height = EXT_W'(h);
      r.base_depth = DEPTH_W'(d);
      r.layer_count = LAYER_W'(layers);
      r.level_request = LEVEL_W'(lv);
      r.block_width = BLK_W'(bw);
      r.block_height = BLK_W'(bh);
      r.block_bytes = BYTES_W'(bb);
      return r;
   endfunction

   function automatic rsp_type mk_level(input int idx, input longint unsigned ofs, size,
                                        input int w, h, d, bx, by, pw, ph,
                                        input longint unsigned fin, input bit last);
      rsp_type r;
      r.level_index = LEVEL_W'(idx);
      r.level_offset = OFS_W'(ofs);
      r.level_bytes = OFS_W'(size);
      r.level_width = EXT_W'(w);
      r.level_height = EXT_W'(h);
      r.level_depth = DEPTH_W'(d);
      r.blocks_per_row = EXT_W'(bx);
      r.block_rows = EXT_W'(by);
      r.padded_row_texels = EXT_W'(pw);
      r.padded_height_texels = EXT_W'(ph);
      r.total_bytes = OFS_W'(fin);
      r.last_level = last;
      return r;
   endfunction

   function automatic row_type pin(input req_type w, input rsp_type lvl);
      row_type r;
      r.word = w;
      r.pinned = 1'b1;
      r.level0 = lvl;
      return r;
   endfunction

   function automatic row_type fresh(input req_type w);
      row_type r;
      r.word = w;
      r.pinned = 1'b0;
      r.level0 = '0;
      return r;
   endfunction

   function automatic req_type noise_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic int rand_extent();
      case ($urandom_range(0, 2))
         0: return 1 << $urandom_range(0, 14);
         1: return $urandom_range(1, 64);
         default: return $urandom_range(1, MAX_EXTENT);
      endcase
   endfunction

   // mostly sane image shapes, some raw noise
   function automatic req_type random_request();
      req_type w;
      if ($urandom_range(0, 99) < 15) return noise_word();
      w.base_width = EXT_W'(rand_extent());
      w.base_height = ($urandom_range(0, 4) == 0) ? EXT_W'(1) : EXT_W'(rand_extent());
      w.base_depth = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(1, 2048))
                                                 : DEPTH_W'(1);
      w.layer_count = ($urandom_range(0, 2) == 0) ? LAYER_W'($urandom_range(1, 2048))
                                                  : LAYER_W'($urandom_range(1, 6));
      w.level_request = ($urandom_range(0, 1) == 0) ? LEVEL_W'(0)
                                                    : LEVEL_W'($urandom_range(1, 15));
      case ($urandom_range(0, 2))
         0: begin
            w.block_width = BLK_W'(1);
            w.block_height = BLK_W'(1);
         end
         1: begin
            w.block_width = BLK_W'(4);
            w.block_height = BLK_W'(4);
         end
         default: begin
            w.block_width = BLK_W'($urandom_range(1, 12));
            w.block_height = BLK_W'($urandom_range(1, 12));
         end
      endcase
      w.block_bytes = BYTES_W'($urandom_range(1, 32));
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // called at a rising edge; returns at the edge that accepts the word, or after the idle gap that ends a burst
   task automatic send_word(input req_type w, input bit pinned, input rsp_type level0);
      int gap;
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      if (w.level_request == 0) full_chains++;
      if (pinned) pending_levels.push_back(level0);
      else plan_mip_chain(w);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         req_word <= noise_word();
         case ($urandom_range(0, 3))
            0: gap = $urandom_range(1, 4);
            1: gap = $urandom_range(5, 60);
            2: gap = $urandom_range(60, 700);
            default: gap = $urandom_range(1, 40);
         endcase
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
   endtask

   always @(posedge clock) begin : level_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected level word, expected none, got %h", $time, rsp_word);
            error_count++;
         end else begin
            want = pending_levels.pop_front();
            levels_checked++;
            check_field("level_index", want.level_index, rsp_word.level_index);
            check_field("level_offset", want.level_offset, rsp_word.level_offset);
            check_field("level_bytes", want.level_bytes, rsp_word.level_bytes);
            check_field("level_width", want.level_width, rsp_word.level_width);
            check_field("level_height", want.level_height, rsp_word.level_height);
            check_field("level_depth", want.level_depth, rsp_word.level_depth);
            check_field("blocks_per_row", want.blocks_per_row, rsp_word.blocks_per_row);
            check_field("block_rows", want.block_rows, rsp_word.block_rows);
            check_field("padded_row_texels", want.padded_row_texels,
                        rsp_word.padded_row_texels);
            check_field("padded_height_texels", want.padded_height_texels,
                        rsp_word.padded_height_texels);
            check_field("total_bytes", want.total_bytes, rsp_word.total_bytes);
            check_field("last_level", want.last_level, rsp_word.last_level);
         end
      end
   end

   initial begin : stimulus
      row_type dir_rows [$];
      dir_rows = '{
         // smallest image, full chain of one level
         pin(mk_req(1, 1, 1, 1, 0, 1, 1, 1),
             mk_level(0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1'b1)),
         // zero extents and zero block shape read as one
         pin(mk_req(0, 0, 0, 1, 0, 0, 0, 1),
             mk_level(0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1'b1)),
         pin(mk_req(16, 16, 1, 0, 1, 4, 4, 16),
             mk_level(0, 0, 0, 16, 16, 1, 4, 4, 16, 16, 0, 1'b1)),
         pin(mk_req(16, 16, 1, 1, 1, 4, 4, 0),
             mk_level(0, 0, 0, 16, 16, 1, 4, 4, 16, 16, 0, 1'b1)),
         // byte count saturates
         pin(mk_req(16384, 16384, 4095, 4095, 1, 1, 1, 63),
             mk_level(0, 0, SAT46, 16384, 16384, 4095, 16384, 16384, 16384, 16384,
                      SAT46, 1'b1)),
         // extent clamp
         pin(mk_req(32767, 32767, 1, 1, 1, 1, 1, 1),
             mk_level(0, 0, 268435456, 16384, 16384, 1, 16384, 16384, 16384, 16384,
                      268435456, 1'b1)),
         pin(mk_req(13, 7, 1, 1, 1, 12, 12, 16),
             mk_level(0, 0, 32, 13, 7, 1, 2, 1, 24, 12, 32, 1'b1)),
         pin(mk_req(16384, 1, 1, 1, 1, 15, 15, 1),
             mk_level(0, 0, 1093, 16384, 1, 1, 1093, 1, 16395, 15, 1093, 1'b1)),
         fresh(mk_req(16384, 16384, 1, 1, 0, 1, 1, 4)),
         fresh(mk_req(32767, 32767, 4095, 4095, 0, 15, 15, 63)),
         fresh(mk_req(1, 1, 1, 1, 15, 1, 1, 4)),
         fresh(mk_req(256, 256, 1, 1, 15, 4, 4, 8)),
         fresh(mk_req(1024, 1, 1, 1, 0, 1, 1, 4)),
         fresh(mk_req(64, 64, 64, 1, 0, 1, 1, 4)),
         fresh(mk_req(1, 1, 2048, 1, 0, 1, 1, 2)),
         fresh(mk_req(1000, 600, 1, 6, 0, 4, 4, 16)),
         fresh(mk_req(37, 29, 1, 3, 0, 5, 4, 16)),
         fresh(mk_req(33, 17, 1, 1, 4, 1, 1, 3)),
         fresh(mk_req(100, 100, 1, 2048, 0, 10, 6, 16)),
         fresh(mk_req(16384, 4, 1, 1, 8, 1, 1, 1)),
         fresh(mk_req(0, 32767, 0, 0, 0, 0, 15, 32))
      };

      burst_left = $urandom_range(1, 20);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].level0);
      repeat (RANDOM_WORDS) send_word(random_request(), 1'b0, '0);
      start <= 1'b0;

      while (pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d layout requests (%0d full chains), %0d mip level words checked,",
               requests_sent, full_chains, levels_checked);
      $display("%0d of them with saturated byte counts", saturated_levels);
      if (error_count == 0) begin
         $display("mip_chain_layout_generator_tb: clean");
      end else begin
         $display("mip_chain_layout_generator_tb: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("mip_chain_layout_generator_tb: errors");
      $finish;
   end

endmodule
